// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the velocity command block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("%m: property check failed");
`define CHK_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("%m: forbidden condition seen");
`else
`define CHK_PROP(lbl, clk, rst_n, prop)
`define CHK_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/tvc_pkg.sv =====
// Package of the trajectory velocity command block: constants, types, tables.
// Depends on nothing.
`timescale 1ns / 1ps
package tvc_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int CORDIC_W = 44;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_LOOKAHEAD = 2'd0,
		CFG_MAX_SPEED = 2'd1,
		CFG_STEP_PER  = 2'd2
	} cfg_idx_t;

	// Configuration as seen by the back end.
	typedef struct packed {
		logic [7:0]  lookahead;
		logic [30:0] max_speed;
		logic [30:0] step_per;
	} cfg_t;

	localparam logic [7:0]  LOOKAHEAD_RST = 8'd10;
	localparam logic [30:0] MAX_SPEED_RST = 31'd32768;
	localparam logic [30:0] STEP_PER_RST  = 31'd3277;

	localparam logic signed [20:0] PI_Q16 = 21'sd205887;
	localparam logic signed [CORDIC_W-1:0] LIM_P = 44'sh00800000000;
	localparam logic signed [CORDIC_W-1:0] LIM_N = 44'shF8000000000;

	localparam logic [17:0] ERR_SET   = 18'd2048;
	localparam logic [17:0] ERR_CLR   = 18'd410;
	localparam logic [17:0] ERR_SLOW  = 18'd819;
	localparam logic [63:0] SPEED_DEC = 64'd655;
	localparam logic [63:0] STEP_CAP  = 64'h0000_0000_FFFF_FFFF;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic [16:0] atan_q16(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0:    v = 17'd51472;
			5'd1:    v = 17'd30386;
			5'd2:    v = 17'd16055;
			5'd3:    v = 17'd8150;
			5'd4:    v = 17'd4091;
			5'd5:    v = 17'd2047;
			5'd6:    v = 17'd1024;
			5'd7:    v = 17'd512;
			5'd8:    v = 17'd256;
			5'd9:    v = 17'd128;
			5'd10:   v = 17'd64;
			5'd11:   v = 17'd32;
			5'd12:   v = 17'd16;
			5'd13:   v = 17'd8;
			5'd14:   v = 17'd4;
			5'd15:   v = 17'd2;
			5'd16:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/tvc_front.sv =====
// Front end: accepts trajectory points, stores them and hands finished
// trajectories to the job queue. Depends on tvc_pkg.
`timescale 1ns / 1ps
module tvc_front #(
	parameter int MAX_POINTS = tvc_pkg::MAX_POINTS_DEF,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [14:0]  robot_heading,
	input  logic                is_last,
	output logic                push,
	output logic [CW+14:0]      push_data,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [31:0]  rd_x,
	output logic signed [31:0]  rd_y
);

	logic signed [31:0] mem_x_q [MAX_POINTS];
	logic signed [31:0] mem_y_q [MAX_POINTS];
	logic [CW-1:0] cnt_q;
	logic          room;
	logic [CW-1:0] cnt_nx;

	// Points past the store depth are dropped but still end a trajectory.
	assign room   = cnt_q < CW'(MAX_POINTS);
	assign cnt_nx = room ? cnt_q + CW'(1) : cnt_q;

	assign push      = accept && is_last;
	assign push_data = {robot_heading, cnt_nx};

	// Point counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= is_last ? '0 : cnt_nx;
		end
	end

	// Point store with a registered read port for the back end.
	always_ff @(posedge clk) begin
		if (accept && room) begin
			mem_x_q[cnt_q[AW-1:0]] <= point_x;
			mem_y_q[cnt_q[AW-1:0]] <= point_y;
		end
		rd_x <= mem_x_q[rd_addr];
		rd_y <= mem_y_q[rd_addr];
	end

endmodule

// ===== hw/rtl/tvc_fifo.sv =====
// Two-entry job queue between front and back end.
// Depends on nothing.
`timescale 1ns / 1ps
module tvc_fifo #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign dout  = mem_q[rp_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= din;
	end

endmodule

// ===== hw/rtl/tvc_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on nothing.
`timescale 1ns / 1ps
module tvc_div #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	logic [W-1:0]         quot_q, den_q;
	logic [W:0]           rem_q, rem_sh, rem_nx;
	logic [$clog2(W+1)-1:0] cnt_q;
	logic                 done_q, ge;

	assign rem_sh = {rem_q[W-1:0], quot_q[W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q[W-1:0];

	// Control: count the quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= ($clog2(W+1))'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - ($clog2(W+1))'(1);
				if (cnt_q == ($clog2(W+1))'(1)) done_q <= 1'b1;
			end
		end
	end

	// Datapath: shift, compare, subtract.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (cnt_q != '0) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[W-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/tvc_back.sv =====
// Back end: works one trajectory into a velocity command with a sequencer
// over CORDIC, square root and the shared divider. Depends on tvc_pkg, tvc_div.
`timescale 1ns / 1ps
module tvc_back #(
	parameter int MAX_POINTS = tvc_pkg::MAX_POINTS_DEF,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tvc_pkg::cfg_t       cfg,
	input  logic                job_valid,
	input  logic [CW+14:0]      job_data,
	output logic                pop,
	output logic [AW-1:0]       rd_addr,
	input  logic signed [31:0]  rd_x,
	input  logic signed [31:0]  rd_y,
	output logic                active,
	output logic                result_valid,
	output logic signed [31:0]  forward_speed,
	output logic signed [31:0]  turn_rate,
	output logic                rotating
);

	localparam int XW = tvc_pkg::CORDIC_W;

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001, S_RD0  = 17'h00002, S_RDK  = 17'h00004,
		S_LOAD = 17'h00008, S_NORM = 17'h00010, S_NEG  = 17'h00020,
		S_CORD = 17'h00040, S_MUL1 = 17'h00080, S_MUL2 = 17'h00100,
		S_SQRT = 17'h00200, S_DIV1 = 17'h00400, S_DIV2 = 17'h00800,
		S_STEP = 17'h01000, S_DEN  = 17'h02000, S_DIV3 = 17'h04000,
		S_DIV4 = 17'h08000, S_OUT  = 17'h10000
	} state_t;

	state_t state_q;
	logic [AW-1:0]        k_q;
	logic signed [14:0]   hd_q;
	logic signed [31:0]   x0_q, y0_q;
	logic signed [32:0]   ddx_q, ddy_q;
	logic signed [XW-1:0] cx_q, cy_q;
	logic signed [20:0]   ang_q;
	logic [4:0]           it_q;
	logic [63:0]          v_q, r_q, bit_q;
	logic [61:0]          vt_q;
	logic [31:0]          c1_q, c2_q, s_q;
	logic [62:0]          den_q;
	logic [63:0]          spd_q;
	logic                 dstart_q;
	logic signed [31:0]   fs_q, tr_q, last_fs_q, last_tr_q;
	logic                 rot_q;

	// Job fields and look-ahead index.
	logic [CW-1:0]      job_n;
	logic signed [14:0] job_hd;
	logic [CW+7:0]      la_w, n_w;
	logic [AW-1:0]      k_sel;
	assign job_n  = job_data[CW-1:0];
	assign job_hd = job_data[CW+14:CW];
	assign la_w   = (CW+8)'(cfg.lookahead);
	assign n_w    = (CW+8)'(job_n);
	assign k_sel  = (la_w >= n_w) ? AW'(job_n >> 1) : AW'(cfg.lookahead);

	// Magnitudes for the distance, scaled below 2^31.
	logic [31:0] ux, uy;
	logic        sh;
	logic [30:0] uxs, uys, mul_a;
	assign ux  = 32'(ddx_q[32] ? -ddx_q : ddx_q);
	assign uy  = 32'(ddy_q[32] ? -ddy_q : ddy_q);
	assign sh  = ux[31] | uy[31];
	assign uxs = sh ? ux[31:1] : ux[30:0];
	assign uys = sh ? uy[31:1] : uy[30:0];
	assign mul_a = state_q == S_MUL1 ? uxs : uys;

	// Heading, heading error and distance.
	logic signed [20:0] ang_r;
	logic signed [16:0] head;
	logic signed [17:0] err;
	logic [17:0]        ae;
	logic [32:0]        dlen;
	logic [30:0]        t_eff;
	assign ang_r = ang_q + 21'sd8;
	assign head  = 17'(ang_r >>> 4);
	assign err   = 18'(head) - 18'(hd_q);
	assign ae    = 18'(err[17] ? -err : err);
	assign dlen  = sh ? {r_q[31:0], 1'b0} : {1'b0, r_q[31:0]};
	assign t_eff = (cfg.step_per == '0) ? 31'd1 : cfg.step_per;

	// Both CORDIC inputs still inside the normalizing window.
	logic in_lim;
	assign in_lim = cx_q < tvc_pkg::LIM_P && cx_q > tvc_pkg::LIM_N &&
		cy_q < tvc_pkg::LIM_P && cy_q > tvc_pkg::LIM_N;

	// CORDIC micro-rotation.
	logic signed [XW-1:0] xs, ys;
	logic signed [20:0]   atn;
	assign xs  = cx_q >>> it_q;
	assign ys  = cy_q >>> it_q;
	assign atn = 21'(tvc_pkg::atan_q16(it_q));

	// Square-root step.
	logic [63:0] rb;
	assign rb = r_q + bit_q;

	// Shared divider and its operand selection.
	logic        div_start, div_done, in_div, div_skip;
	logic [63:0] div_num, div_den, div_q, div_r;
	assign in_div   = state_q == S_DIV1 || state_q == S_DIV2 ||
		state_q == S_DIV3 || state_q == S_DIV4;
	assign div_skip = state_q == S_DIV1 && (dlen == '0 || cfg.max_speed == '0);
	assign div_start = in_div && !dstart_q && !div_skip;

	always_comb begin
		case (state_q)
			S_DIV1: begin
				div_num = 64'({dlen, 16'd0});
				div_den = 64'(vt_q);
			end
			S_DIV2: begin
				div_num = 64'({ae, 4'd0});
				div_den = 64'(t_eff);
			end
			S_DIV3: begin
				div_num = 64'({dlen, 16'd0});
				div_den = 64'(den_q);
			end
			default: begin
				div_num = 64'({ae, 20'd0});
				div_den = 64'(den_q);
			end
		endcase
	end

	tvc_div #(.W(64)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_q),
		.rem   (div_r)
	);

	// Rounded-up quotient limited to the step cap.
	logic [63:0] cq;
	logic [31:0] c_cap;
	assign cq    = div_q + 64'(div_r != '0);
	assign c_cap = (cq > tvc_pkg::STEP_CAP) ? 32'hFFFF_FFFF : cq[31:0];

	// Step count as the largest of the three bounds.
	logic [31:0] s0, s01;
	assign s0  = (k_q == '0) ? 32'd1 : 32'(k_q);
	assign s01 = (c1_q > s0) ? c1_q : s0;

	// Command and hysteresis update.
	logic        rot_nx;
	logic [63:0] spd_adj, tturn;
	always_comb begin
		rot_nx = rot_q;
		if (ae > tvc_pkg::ERR_SET) rot_nx = 1'b1;
		if (rot_nx && ae < tvc_pkg::ERR_CLR) rot_nx = 1'b0;
		if (rot_nx) begin
			spd_adj = '0;
		end else if (ae > tvc_pkg::ERR_SLOW && spd_q >= tvc_pkg::SPEED_DEC) begin
			spd_adj = spd_q - tvc_pkg::SPEED_DEC;
		end else begin
			spd_adj = spd_q;
		end
		tturn = err[17] ? -div_q : div_q;
	end

	// Memory address per read state.
	assign rd_addr      = (state_q == S_RDK) ? k_q : '0;
	assign pop          = state_q == S_IDLE && job_valid;
	assign active       = state_q != S_IDLE;
	assign result_valid = state_q == S_OUT;
	assign forward_speed = fs_q;
	assign turn_rate     = tr_q;
	assign rotating      = rot_q;

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dstart_q  <= 1'b0;
			rot_q     <= 1'b0;
			last_fs_q <= '0;
			last_tr_q <= '0;
		end else begin
			if (div_start) dstart_q <= 1'b1;
			if (div_done) dstart_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						if (job_n <= CW'(5)) begin
							last_fs_q <= '0;
							last_tr_q <= '0;
							state_q   <= S_OUT;
						end else begin
							state_q <= S_RD0;
						end
					end
				end
				S_RD0: state_q <= S_RDK;
				S_RDK: state_q <= S_LOAD;
				S_LOAD: state_q <= S_NORM;
				S_NORM: begin
					if (ddx_q == '0 && ddy_q == '0) begin
						state_q <= S_MUL1;
					end else if (!in_lim) begin
						state_q <= S_NEG;
					end
				end
				S_NEG: state_q <= S_CORD;
				S_CORD: if (it_q == 5'd16) state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SQRT;
				S_SQRT: if (bit_q == 64'd1) state_q <= S_DIV1;
				S_DIV1: if (div_skip || div_done) state_q <= S_DIV2;
				S_DIV2: if (div_done) state_q <= S_STEP;
				S_STEP: state_q <= S_DEN;
				S_DEN:  state_q <= S_DIV3;
				S_DIV3: if (div_done) state_q <= S_DIV4;
				S_DIV4: begin
					if (div_done) begin
						rot_q     <= rot_nx;
						last_fs_q <= spd_adj[31:0];
						last_tr_q <= tturn[31:0];
						state_q   <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				k_q  <= k_sel;
				hd_q <= job_hd;
				fs_q <= last_fs_q;
				tr_q <= last_tr_q;
			end
			S_RDK: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
			end
			S_LOAD: begin
				ddx_q <= 33'(rd_x) - 33'(x0_q);
				ddy_q <= 33'(rd_y) - 33'(y0_q);
				cx_q  <= XW'(33'(rd_x) - 33'(x0_q));
				cy_q  <= XW'(33'(rd_y) - 33'(y0_q));
				ang_q <= '0;
				vt_q  <= 62'(cfg.max_speed) * 62'(t_eff);
			end
			S_NORM: begin
				// Double only while both inputs stay inside the window.
				if (in_lim) begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
				end
			end
			S_NEG: begin
				// Fold the left half-plane onto the right one.
				if (cx_q < 0) begin
					ang_q <= (cy_q >= 0) ? tvc_pkg::PI_Q16 : -tvc_pkg::PI_Q16;
					cx_q  <= -cx_q;
					cy_q  <= -cy_q;
				end
				it_q <= '0;
			end
			S_CORD: begin
				if (cy_q > 0) begin
					cx_q  <= cx_q + ys;
					cy_q  <= cy_q - xs;
					ang_q <= ang_q + atn;
				end else begin
					cx_q  <= cx_q - ys;
					cy_q  <= cy_q + xs;
					ang_q <= ang_q - atn;
				end
				it_q <= it_q + 5'd1;
			end
			S_MUL1: v_q <= 64'(mul_a) * 64'(mul_a);
			S_MUL2: begin
				v_q   <= v_q + 64'(mul_a) * 64'(mul_a);
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			S_SQRT: begin
				if (v_q >= rb) begin
					v_q <= v_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIV1: begin
				if (div_skip) c1_q <= (dlen == '0) ? 32'd0 : 32'hFFFF_FFFF;
				else if (div_done) c1_q <= c_cap;
			end
			S_DIV2: if (div_done) c2_q <= c_cap;
			S_STEP: s_q <= (c2_q > s01) ? c2_q : s01;
			S_DEN:  den_q <= 63'(s_q) * 63'(t_eff);
			S_DIV3: if (div_done) spd_q <= div_q;
			S_DIV4: begin
				if (div_done) begin
					fs_q <= spd_adj[31:0];
					tr_q <= tturn[31:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/trajectory_velocity_command.sv =====
// Trajectory velocity command. A point is taken while busy is low; a non-final
// point leaves busy low. A final point keeps busy high through four runs of
// the shared divider (the first is skipped at zero distance or zero speed
// limit), a 32-step square root, 17 CORDIC steps and the normalizing steps;
// a short trajectory skips this work. The result is a one-cycle strobe in the
// last busy cycle and cannot be stalled. Reset (arst_n) clears counters, flag,
// stored command and configuration registers, not the store.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trajectory_velocity_command #(
	parameter int MAX_POINTS = tvc_pkg::MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [14:0] robot_heading,
	input  logic               is_last,
	output logic               result_valid,
	output logic signed [31:0] forward_speed,
	output logic signed [31:0] turn_rate,
	output logic               rotating,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_addr,
	input  logic [30:0]        cfg_data
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int JW = CW + 15;

	tvc_pkg::cfg_t cfg_q;
	logic          accept, push, pop, fifo_empty, fifo_full, back_active;
	logic [JW-1:0] push_data, job_data;
	logic [AW-1:0] rd_addr;
	logic signed [31:0] rd_x, rd_y;

	assign cfg_ready = 1'b1;
	assign busy      = !fifo_empty || back_active;
	assign accept    = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lookahead <= tvc_pkg::LOOKAHEAD_RST;
			cfg_q.max_speed <= tvc_pkg::MAX_SPEED_RST;
			cfg_q.step_per  <= tvc_pkg::STEP_PER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				tvc_pkg::CFG_LOOKAHEAD: cfg_q.lookahead <= cfg_data[7:0];
				tvc_pkg::CFG_MAX_SPEED: cfg_q.max_speed <= cfg_data;
				tvc_pkg::CFG_STEP_PER:  cfg_q.step_per  <= cfg_data;
				default: ;
			endcase
		end
	end

	tvc_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.point_x      (point_x),
		.point_y      (point_y),
		.robot_heading(robot_heading),
		.is_last      (is_last),
		.push         (push),
		.push_data    (push_data),
		.rd_addr      (rd_addr),
		.rd_x         (rd_x),
		.rd_y         (rd_y)
	);

	tvc_fifo #(.W(JW)) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_data),
		.pop   (pop),
		.dout  (job_data),
		.empty (fifo_empty),
		.full  (fifo_full)
	);

	tvc_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.job_valid    (!fifo_empty),
		.job_data     (job_data),
		.pop          (pop),
		.rd_addr      (rd_addr),
		.rd_x         (rd_x),
		.rd_y         (rd_y),
		.active       (back_active),
		.result_valid (result_valid),
		.forward_speed(forward_speed),
		.turn_rate    (turn_rate),
		.rotating     (rotating)
	);

	// A result beat only comes while a trajectory is being worked.
	`CHK_PROP(a_result_busy, clk, arst_n, result_valid |-> busy)
	// The queue is never written when full.
	`CHK_NEVER(a_no_overflow, clk, arst_n, push && fifo_full)
	// A final point locks out new points on the next cycle.
	`CHK_PROP(a_last_locks, clk, arst_n, (accept && is_last) |=> busy)

endmodule

// ===== tb/sv/tb_trajectory_velocity_command.sv =====
// Self-checking testbench of trajectory_velocity_command: random trajectories
// against a built-in command predictor. Depends on tvc_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_trajectory_velocity_command;

	localparam int NPTS = 256;
	localparam longint PI_RAD = 205887;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [31:0] fs;
		logic signed [31:0] tr;
		logic               rot;
	} cmd_t;

	typedef struct {
		int    x;
		int    y;
		int    h;
		bit    last;
		bit    typed;
		cmd_t  want;
	} pt_row_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic signed [31:0] point_x = 0;
	logic signed [31:0] point_y = 0;
	logic signed [14:0] robot_heading = 0;
	logic               is_last = 0;
	logic               result_valid;
	logic signed [31:0] forward_speed;
	logic signed [31:0] turn_rate;
	logic               rotating;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_addr = 0;
	logic [30:0]        cfg_data = 0;

	trajectory_velocity_command DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .robot_heading(robot_heading),
		.is_last(is_last), .result_valid(result_valid),
		.forward_speed(forward_speed), .turn_rate(turn_rate), .rotating(rotating),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// Predictor state and configuration.
	logic signed [31:0] trk_x [NPTS];
	logic signed [31:0] trk_y [NPTS];
	int unsigned        trk_count = 0;
	bit                 stop_turn = 0;
	logic signed [31:0] prev_fs = 0;
	logic signed [31:0] prev_tr = 0;
	logic [7:0]         look_idx = tvc_pkg::LOOKAHEAD_RST;
	logic [63:0]        speed_lim = 64'(tvc_pkg::MAX_SPEED_RST);
	logic [63:0]        step_time = 64'(tvc_pkg::STEP_PER_RST);

	cmd_t   cmd_queue [$];
	int     errors = 0;
	int     n_items = 0;
	int     n_cmds = 0;
	longint cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Heading of (dx, dy) in Q3.12 radians by CORDIC on pre-scaled inputs.
	function automatic longint heading_of(longint dx, longint dy);
		longint ang, xs, ys, lim;
		longint tab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
			128, 64, 32, 16, 8, 4, 2, 1};
		ang = 0;
		lim = 64'sd1 << 39;
		if (dx == 0 && dy == 0)
			return 0;
		while (dx < lim && dx > -lim && dy < lim && dy > -lim) begin
			dx = dx * 2;
			dy = dy * 2;
		end
		if (dx < 0) begin
			ang = (dy >= 0) ? PI_RAD : -PI_RAD;
			dx = -dx;
			dy = -dy;
		end
		for (int i = 0; i < 17; i++) begin
			xs = dx >>> i;
			ys = dy >>> i;
			if (dy > 0) begin
				dx += ys; dy -= xs; ang += tab[i];
			end else begin
				dx -= ys; dy += xs; ang -= tab[i];
			end
		end
		return (ang + 8) >>> 4;
	endfunction

	// Floor of the Euclidean length, Q16.16, with pre-shift to keep the sum of squares in 63 bits.
	function automatic logic [63:0] length_of(longint dx, longint dy);
		logic [63:0] ux, uy, v, r, b;
		int sh;
		ux = (dx < 0) ? -dx : dx;
		uy = (dy < 0) ? -dy : dy;
		sh = 0;
		while ((ux >> sh) >= 64'h8000_0000 || (uy >> sh) >= 64'h8000_0000)
			sh++;
		ux = ux >> sh;
		uy = uy >> sh;
		v = ux * ux + uy * uy;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r << sh;
	endfunction

	// Store one point; on a final point work out the command it produces.
	function automatic bit predict_command(input logic signed [31:0] x,
		input logic signed [31:0] y, input logic signed [14:0] h, input bit last,
		output cmd_t c);
		int unsigned n, k;
		longint dx, dy, e;
		logic [63:0] ae, dlen, t, s, q, lim, den, spd, tmag;
		if (trk_count < NPTS) begin
			trk_x[trk_count] = x;
			trk_y[trk_count] = y;
			trk_count++;
		end
		if (!last)
			return 0;
		n = trk_count;
		trk_count = 0;
		if (n <= 5) begin
			c = '{prev_fs, prev_tr, stop_turn};
			prev_fs = 0;
			prev_tr = 0;
			return 1;
		end
		k = 32'(look_idx);
		if (k >= n)
			k = n / 2;
		dx = longint'(trk_x[k]) - longint'(trk_x[0]);
		dy = longint'(trk_y[k]) - longint'(trk_y[0]);
		e = heading_of(dx, dy) - longint'(h);
		ae = (e < 0) ? -e : e;
		dlen = length_of(dx, dy);
		t = (step_time != 0) ? step_time : 64'd1;
		s = (k != 0) ? 64'(k) : 64'd1;
		if (dlen > 0) begin
			if (speed_lim == 0) begin
				lim = tvc_pkg::STEP_CAP;
			end else begin
				q = speed_lim * t;
				lim = (dlen * 65536 + q - 1) / q;
			end
			if (lim > tvc_pkg::STEP_CAP)
				lim = tvc_pkg::STEP_CAP;
			if (lim > s)
				s = lim;
		end
		lim = (ae * 16 + t - 1) / t;
		if (lim > tvc_pkg::STEP_CAP)
			lim = tvc_pkg::STEP_CAP;
		if (lim > s)
			s = lim;
		den = s * t;
		spd = (dlen * 65536) / den;
		tmag = (ae << 20) / den;
		// Stop-to-rotate hysteresis and the slow-down on moderate errors.
		if (ae > tvc_pkg::ERR_SET)
			stop_turn = 1;
		if (stop_turn && ae < tvc_pkg::ERR_CLR)
			stop_turn = 0;
		if (stop_turn)
			spd = 0;
		else if (ae > tvc_pkg::ERR_SLOW && spd >= tvc_pkg::SPEED_DEC)
			spd = spd - tvc_pkg::SPEED_DEC;
		prev_fs = spd[31:0];
		prev_tr = (e < 0) ? -tmag[31:0] : tmag[31:0];
		c = '{prev_fs, prev_tr, stop_turn};
		return 1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one point beat; called at a falling edge, returns at one.
	task automatic send_point(input int x, input int y, input int h, input bit last,
		input bit typed, input cmd_t want, input bit idle);
		cmd_t c;
		int g;
		start <= 1;
		point_x <= x;
		point_y <= y;
		robot_heading <= h[14:0];
		is_last <= last;
		do
			@(posedge clk);
		while (busy);
		n_items++;
		if (predict_command(x, y, h[14:0], last, c))
			cmd_queue.insert(cmd_queue.size(), typed ? want : c);
		@(negedge clk);
		g = idle ? pick_gap() : 0;
		if (g > 0) begin
			start <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	// Wait until every command has come out and the block has settled.
	task automatic drain();
		start <= 0;
		while (cmd_queue.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(input tvc_pkg::cfg_idx_t a, input logic [30:0] d);
		cfg_valid <= 1;
		cfg_addr <= a;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (a)
			tvc_pkg::CFG_LOOKAHEAD: look_idx = d[7:0];
			tvc_pkg::CFG_MAX_SPEED: speed_lim = 64'(d);
			tvc_pkg::CFG_STEP_PER:  step_time = 64'(d);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// One trajectory: a walk with random steps, the odd wild point, a final flag.
	task automatic send_path(input int n);
		int x, y, sx, sy, h, r;
		bit idle;
		cmd_t none;
		none = '{0, 0, 0};
		idle = ($urandom_range(3) != 0);
		r = $urandom_range(9);
		x = (r < 2) ? $urandom : $urandom_range(0, 2000000) - 1000000;
		y = (r < 2) ? $urandom : $urandom_range(0, 2000000) - 1000000;
		sx = $urandom_range(0, 131072) - 65536;
		sy = $urandom_range(0, 131072) - 65536;
		for (int i = 0; i < n; i++) begin
			h = ($urandom_range(9) < 4) ? $urandom_range(0, 32767) - 16384
				: $urandom_range(0, 6000) - 3000;
			if ($urandom_range(19) == 0)
				send_point($urandom, $urandom, h, i == n - 1, 0, none, idle);
			else
				send_point(x, y, h, i == n - 1, 0, none, idle);
			x += sx + $urandom_range(0, 8192) - 4096;
			y += sy + $urandom_range(0, 8192) - 4096;
		end
	endtask

	// Compare each command beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (cmd_queue.size() == 0) begin
				$error("unexpected command: fs=%0d tr=%0d rot=%0b",
					forward_speed, turn_rate, rotating);
				errors++;
			end else begin
				cmd_t w;
				w = cmd_queue.pop_front();
				n_cmds++;
				if (forward_speed !== w.fs) begin
					$error("forward_speed expected %0d got %0d", w.fs, forward_speed);
					errors++;
				end
				if (turn_rate !== w.tr) begin
					$error("turn_rate expected %0d got %0d", w.tr, turn_rate);
					errors++;
				end
				if (rotating !== w.rot) begin
					$error("rotating expected %0b got %0b", w.rot, rotating);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Directed rows: a single-point trajectory after reset, a degenerate one with all
	// points equal, full-scale coordinates with extreme headings, a short one.
	pt_row_t directed [21] = '{
		'{0, 0, 0, 1, 1, '{0, 0, 0}},
		'{5, 5, 0, 0, 0, '{0, 0, 0}},
		'{5, 5, 0, 0, 0, '{0, 0, 0}},
		'{5, 5, 0, 0, 0, '{0, 0, 0}},
		'{5, 5, 0, 0, 0, '{0, 0, 0}},
		'{5, 5, 0, 0, 0, '{0, 0, 0}},
		'{5, 5, 0, 1, 1, '{0, 0, 0}},
		'{32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0}},
		'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, -16384, 1, 0, '{0, 0, 0}},
		'{32'sh7FFF_FFFF, 0, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0}},
		'{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 0, 0, 0, '{0, 0, 0}},
		'{0, 0, 16383, 1, 0, '{0, 0, 0}},
		'{1, 1, 0, 0, 0, '{0, 0, 0}},
		'{2, 2, 0, 1, 0, '{0, 0, 0}}
	};

	initial begin
		logic [7:0]  la;
		logic [30:0] vm, tp;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (directed[i])
			send_point(directed[i].x, directed[i].y, directed[i].h, directed[i].last,
				directed[i].typed, directed[i].want, 0);
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin la = 8'd1;   vm = 31'h7FFF_FFFF; tp = 31'd1; end
				1: begin la = 8'd255; vm = 31'd0;         tp = 31'h7FFF_FFFF; end
				2: begin la = 8'd0;   vm = 31'd1;         tp = 31'd0; end
				3: begin la = 8'd10;  vm = 31'd32768;     tp = 31'd3277; end
				default: begin
					la = 8'($urandom_range(1, 40));
					vm = 31'($urandom_range(1000, 400000));
					tp = 31'($urandom_range(300, 70000));
				end
			endcase
			write_reg(tvc_pkg::CFG_LOOKAHEAD, 31'(la));
			write_reg(tvc_pkg::CFG_MAX_SPEED, vm);
			write_reg(tvc_pkg::CFG_STEP_PER, tp);
			while (n_items < 21 + (p + 1) * 175) begin
				if ($urandom_range(9) == 0)
					send_path($urandom_range(1, 5));
				else
					send_path($urandom_range(6, 40));
			end
			if (p == 3)
				send_path($urandom_range(258, 280));
			drain();
		end

		repeat (400) @(negedge clk);
		if (cmd_queue.size() != 0) begin
			$error("%0d commands never came out", cmd_queue.size());
			errors++;
		end
		$display("Sent %0d trajectory points over 8 register settings; checked %0d commands.",
			n_items, n_cmds);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
